[src/cau_pkg.sv]
// Shared types, codes and the saturation helper of the complex arithmetic unit.
// Depends on nothing; the design files use it by scoped names, the testbench files import it.
package cau_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_BITS     = 2 * WORD_BITS;
  localparam int SUM_BITS      = 2 * WORD_BITS + 1;

  typedef logic [2:0] func_t;
  localparam func_t FUNC_ADD  = 3'd0;
  localparam func_t FUNC_SUB  = 3'd1;
  localparam func_t FUNC_MUL  = 3'd2;
  localparam func_t FUNC_DIV  = 3'd3;
  localparam func_t FUNC_NEG  = 3'd4;
  localparam func_t FUNC_CONJ = 3'd5;
  localparam func_t FUNC_MAG  = 3'd6;
  localparam func_t FUNC_NOP  = 3'd7;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_SAT  = 2'd1;
  localparam status_t ST_DIV0 = 2'd2;

  typedef struct packed {
    func_t                       func;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    status_t                     status;
  } out_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        sat;
  } part_t;

  // per-beat control carried down the pipe
  typedef struct packed {
    logic                 valid;
    logic                 is_div;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 sat;
    logic [WORD_BITS-1:0] re;
    logic [WORD_BITS-1:0] im;
  } ctl_t;

  // sign-magnitude to saturated two's complement word
  function automatic part_t clamp_sm(input logic neg, input logic [SUM_BITS-1:0] mag);
    part_t               p;
    logic [SUM_BITS-1:0] lim;
    logic [SUM_BITS-1:0] m;
    lim   = neg ? (SUM_BITS'(1) << (WORD_BITS - 1))
                : ((SUM_BITS'(1) << (WORD_BITS - 1)) - SUM_BITS'(1));
    m     = (mag > lim) ? lim : mag;
    p.sat = (mag > lim);
    p.val = neg ? -m[WORD_BITS-1:0] : m[WORD_BITS-1:0];
    return p;
  endfunction

endpackage

[src/cau_front.sv]
// Front pipe: input register, products, sums, sign/magnitude, divide setup.
// Depends on cau_pkg.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cau_pkg::in_t         item,
  output cau_pkg::ctl_t        ctl,
  output logic [cau_pkg::PROD_BITS-1:0] d,
  output logic [cau_pkg::SUM_BITS+FRAC_BITS-1:0] r_re,
  output logic [cau_pkg::SUM_BITS+FRAC_BITS-1:0] r_im
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PB = cau_pkg::PROD_BITS;
  localparam int SB = cau_pkg::SUM_BITS;
  localparam int PW = W + 1;
  localparam int RW = SB + FRAC_BITS;
  localparam int CW = SB + W;

  // stage A
  logic         va;
  cau_pkg::in_t ia;

  // stage B
  logic                 vb;
  cau_pkg::func_t       fb;
  logic signed [PB-1:0] p0, p1, p2, p3, sr, si;
  logic signed [PW-1:0] pl_re, pl_im;
  logic signed [W-1:0]  x0, x1;
  logic signed [PW-1:0] pl_re_next, pl_im_next;

  // stage C
  logic                 vc;
  cau_pkg::func_t       fc;
  logic signed [SB-1:0] sum_re, sum_im;
  logic [PB-1:0]        d_c;
  cau_pkg::part_t       plr, pli;
  logic [PW-1:0]        abs_re, abs_im;

  // stage D
  cau_pkg::ctl_t        ctl_d;
  cau_pkg::ctl_t        ctl_d_next;
  logic [SB-1:0]        mag_re, mag_im;
  logic [PB-1:0]        d_d;
  logic                 neg_re, neg_im;
  logic [SB-1:0]        mre_next, mim_next;
  cau_pkg::part_t       pr, pi;

  // stage E
  cau_pkg::ctl_t        ctl_next;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= start;
    ia <= item;
  end

  always_comb begin
    x0 = (ia.func == cau_pkg::FUNC_MAG) ? ia.a_re : ia.b_re;
    x1 = (ia.func == cau_pkg::FUNC_MAG) ? ia.a_im : ia.b_im;
    pl_re_next = '0;
    pl_im_next = '0;
    case (ia.func)
      cau_pkg::FUNC_ADD: begin
        pl_re_next = PW'(ia.a_re) + PW'(ia.b_re);
        pl_im_next = PW'(ia.a_im) + PW'(ia.b_im);
      end
      cau_pkg::FUNC_SUB: begin
        pl_re_next = PW'(ia.a_re) - PW'(ia.b_re);
        pl_im_next = PW'(ia.a_im) - PW'(ia.b_im);
      end
      cau_pkg::FUNC_NEG: begin
        pl_re_next = -PW'(ia.a_re);
        pl_im_next = -PW'(ia.a_im);
      end
      cau_pkg::FUNC_CONJ: begin
        pl_re_next = PW'(ia.a_re);
        pl_im_next = -PW'(ia.a_im);
      end
      default: begin
        pl_re_next = '0;
        pl_im_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
    fb    <= ia.func;
    p0    <= ia.a_re * x0;
    p1    <= ia.a_im * x1;
    p2    <= ia.a_re * ia.b_im;
    p3    <= ia.a_im * ia.b_re;
    sr    <= ia.b_re * ia.b_re;
    si    <= ia.b_im * ia.b_im;
    pl_re <= pl_re_next;
    pl_im <= pl_im_next;
  end

  assign abs_re = pl_re[PW-1] ? PW'(-pl_re) : PW'(pl_re);
  assign abs_im = pl_im[PW-1] ? PW'(-pl_im) : PW'(pl_im);

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= vb;
    fc     <= fb;
    sum_re <= (fb == cau_pkg::FUNC_MUL) ? SB'(p0) - SB'(p1) : SB'(p0) + SB'(p1);
    sum_im <= (fb == cau_pkg::FUNC_DIV) ? SB'(p3) - SB'(p2) : SB'(p2) + SB'(p3);
    d_c    <= PB'(sr) + PB'(si);
    plr    <= cau_pkg::clamp_sm(pl_re[PW-1], SB'(abs_re));
    pli    <= cau_pkg::clamp_sm(pl_im[PW-1], SB'(abs_im));
  end

  assign neg_re   = sum_re[SB-1];
  assign neg_im   = sum_im[SB-1];
  assign mre_next = neg_re ? SB'(-sum_re) : SB'(sum_re);
  assign mim_next = neg_im ? SB'(-sum_im) : SB'(sum_im);
  assign pr = cau_pkg::clamp_sm(neg_re, mre_next >> FRAC_BITS);
  assign pi = cau_pkg::clamp_sm(neg_im, mim_next >> FRAC_BITS);

  always_comb begin
    ctl_d_next        = '0;
    ctl_d_next.valid  = vc;
    ctl_d_next.is_div = (fc == cau_pkg::FUNC_DIV);
    ctl_d_next.dz     = (d_c == '0);
    ctl_d_next.neg_re = neg_re;
    ctl_d_next.neg_im = neg_im;
    case (fc)
      cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB, cau_pkg::FUNC_NEG, cau_pkg::FUNC_CONJ: begin
        ctl_d_next.re  = plr.val;
        ctl_d_next.im  = pli.val;
        ctl_d_next.sat = plr.sat | pli.sat;
      end
      cau_pkg::FUNC_MUL: begin
        ctl_d_next.re  = pr.val;
        ctl_d_next.im  = pi.val;
        ctl_d_next.sat = pr.sat | pi.sat;
      end
      cau_pkg::FUNC_MAG: begin
        ctl_d_next.re  = pr.val;
        ctl_d_next.sat = pr.sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_d <= '0;
    else     ctl_d <= ctl_d_next;
    mag_re <= mre_next;
    mag_im <= mim_next;
    d_d    <= d_c;
  end

  // quotient fits the word only if mag < d * 2^(W-F)
  always_comb begin
    ctl_next        = ctl_d;
    ctl_next.ovf_re = CW'(mag_re) >= (CW'(d_d) << (W - FRAC_BITS));
    ctl_next.ovf_im = CW'(mag_im) >= (CW'(d_d) << (W - FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) ctl <= '0;
    else     ctl <= ctl_next;
    d    <= d_d;
    r_re <= RW'(mag_re) << FRAC_BITS;
    r_im <= RW'(mag_im) << FRAC_BITS;
  end

endmodule

[src/cau_div_step.sv]
// One restoring divide stage: decides quotient bit STEP for both parts.
// Depends on cau_pkg.
module cau_div_step #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int STEP      = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cau_pkg::ctl_t                          ctl_i,
  input  logic [cau_pkg::PROD_BITS-1:0]          d_i,
  input  logic [cau_pkg::SUM_BITS+FRAC_BITS-1:0] r_re_i,
  input  logic [cau_pkg::SUM_BITS+FRAC_BITS-1:0] r_im_i,
  input  logic [cau_pkg::WORD_BITS-1:0]          q_re_i,
  input  logic [cau_pkg::WORD_BITS-1:0]          q_im_i,
  output cau_pkg::ctl_t                          ctl_o,
  output logic [cau_pkg::PROD_BITS-1:0]          d_o,
  output logic [cau_pkg::SUM_BITS+FRAC_BITS-1:0] r_re_o,
  output logic [cau_pkg::SUM_BITS+FRAC_BITS-1:0] r_im_o,
  output logic [cau_pkg::WORD_BITS-1:0]          q_re_o,
  output logic [cau_pkg::WORD_BITS-1:0]          q_im_o
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int RW = cau_pkg::SUM_BITS + FRAC_BITS;
  localparam int CW = RW + W;

  logic [CW-1:0] ds;
  logic          ge_re, ge_im;
  logic [W-1:0]  q_re_next, q_im_next;

  assign ds    = CW'(d_i) << STEP;
  assign ge_re = CW'(r_re_i) >= ds;
  assign ge_im = CW'(r_im_i) >= ds;

  always_comb begin
    q_re_next       = q_re_i;
    q_im_next       = q_im_i;
    q_re_next[STEP] = ge_re;
    q_im_next[STEP] = ge_im;
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_o <= '0;
    else     ctl_o <= ctl_i;
    d_o    <= d_i;
    r_re_o <= ge_re ? RW'(CW'(r_re_i) - ds) : r_re_i;
    r_im_o <= ge_im ? RW'(CW'(r_im_i) - ds) : r_im_i;
    q_re_o <= q_re_next;
    q_im_o <= q_im_next;
  end

endmodule

[src/cau_back.sv]
// Output stage: picks quotient or carried result, saturates, drives the beat.
// Depends on cau_pkg.
module cau_back (
  input  logic                          clk,
  input  logic                          rst,
  input  cau_pkg::ctl_t                 ctl,
  input  logic [cau_pkg::WORD_BITS-1:0] q_re,
  input  logic [cau_pkg::WORD_BITS-1:0] q_im,
  output logic                          done,
  output cau_pkg::out_t                 result
);

  localparam int SB = cau_pkg::SUM_BITS;

  cau_pkg::part_t qr, qi;
  cau_pkg::out_t  res_next;

  // an overflowed quotient is forced past any limit
  assign qr = cau_pkg::clamp_sm(ctl.neg_re,
                                ctl.ovf_re ? (SB'(1) << (SB - 1)) : SB'(q_re));
  assign qi = cau_pkg::clamp_sm(ctl.neg_im,
                                ctl.ovf_im ? (SB'(1) << (SB - 1)) : SB'(q_im));

  always_comb begin
    if (ctl.is_div && ctl.dz) begin
      res_next.res_re = '0;
      res_next.res_im = '0;
      res_next.status = cau_pkg::ST_DIV0;
    end else if (ctl.is_div) begin
      res_next.res_re = qr.val;
      res_next.res_im = qi.val;
      res_next.status = (qr.sat | qi.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      res_next.res_re = ctl.re;
      res_next.res_im = ctl.im;
      res_next.status = ctl.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ctl.valid;
    result <= res_next;
  end

endmodule

[src/complex_arithmetic_unit.sv]
// Complex arithmetic unit, top level: front pipe, divider stages, output stage.
// Depends on cau_pkg, cau_front, cau_div_step and cau_back.
//
// Takes one operation per clock (busy stays low). done rises for every
// operation alike, as a single-cycle beat, after it has passed five front
// stages, the restoring divider with one quotient bit per stage, and the
// output register. The receiver cannot stall, so done must be sampled in
// the cycle it is high.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cau_pkg::in_t  item,
  output logic          done,
  output cau_pkg::out_t result
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int RW = cau_pkg::SUM_BITS + FRAC_BITS;

  cau_pkg::ctl_t                 ctl_s  [0:W];
  logic [cau_pkg::PROD_BITS-1:0] d_s    [0:W];
  logic [RW-1:0]                 r_re_s [0:W];
  logic [RW-1:0]                 r_im_s [0:W];
  logic [W-1:0]                  q_re_s [0:W];
  logic [W-1:0]                  q_im_s [0:W];

  assign busy      = 1'b0;
  assign q_re_s[0] = '0;
  assign q_im_s[0] = '0;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .ctl   (ctl_s[0]),
    .d     (d_s[0]),
    .r_re  (r_re_s[0]),
    .r_im  (r_im_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_div
    cau_div_step #(.FRAC_BITS(FRAC_BITS), .STEP(W - 1 - i)) u_step (
      .clk    (clk),
      .rst    (rst),
      .ctl_i  (ctl_s[i]),
      .d_i    (d_s[i]),
      .r_re_i (r_re_s[i]),
      .r_im_i (r_im_s[i]),
      .q_re_i (q_re_s[i]),
      .q_im_i (q_im_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .d_o    (d_s[i+1]),
      .r_re_o (r_re_s[i+1]),
      .r_im_o (r_im_s[i+1]),
      .q_re_o (q_re_s[i+1]),
      .q_im_o (q_im_s[i+1])
    );
  end

  cau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl_s[W]),
    .q_re   (q_re_s[W]),
    .q_im   (q_im_s[W]),
    .done   (done),
    .result (result)
  );

endmodule

[verif/cau_checker.sv]
`timescale 1ns / 1ps
// Result checker for the complex arithmetic unit: predicts each beat from its operands
// and compares it with the result beats. Depends on cau_pkg.
module cau_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  cau_pkg::in_t  item,
  input  logic          done,
  input  cau_pkg::out_t result,
  output int            fail_count,
  output int            pending_count
);
  import cau_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  out_t expected_results[$];

  // sign-magnitude to a saturated 32-bit word
  function automatic logic [31:0] word_clamp(input logic neg, input logic [127:0] mag,
                                             inout logic sat);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    m = mag;
    if (m > lim) begin
      m = lim;
      sat = 1'b1;
    end
    return neg ? -m[31:0] : m[31:0];
  endfunction

  function automatic logic [31:0] exact_part(input logic signed [127:0] v, input int shift,
                                             inout logic sat);
    logic         neg;
    logic [127:0] mag;
    neg = v < 0;
    mag = neg ? -v : v;
    return word_clamp(neg, mag >> shift, sat);
  endfunction

  function automatic logic [31:0] quot_part(input logic signed [127:0] n,
                                            input logic [127:0] d, inout logic sat);
    logic         neg;
    logic [127:0] mag;
    neg = n < 0;
    mag = neg ? -n : n;
    return word_clamp(neg, (mag << FB) / d, sat);
  endfunction

  function automatic out_t predict_result(input in_t x);
    out_t              r;
    logic              sat;
    logic signed [127:0] ar, ai, br, bi, den;
    ar = x.a_re;
    ai = x.a_im;
    br = x.b_re;
    bi = x.b_im;
    sat = 1'b0;
    r = '0;
    r.status = ST_OK;
    case (x.func)
      FUNC_ADD: begin
        r.res_re = exact_part(ar + br, 0, sat);
        r.res_im = exact_part(ai + bi, 0, sat);
      end
      FUNC_SUB: begin
        r.res_re = exact_part(ar - br, 0, sat);
        r.res_im = exact_part(ai - bi, 0, sat);
      end
      FUNC_MUL: begin
        r.res_re = exact_part(ar * br - ai * bi, FB, sat);
        r.res_im = exact_part(ar * bi + ai * br, FB, sat);
      end
      FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DIV0;
        end else begin
          r.res_re = quot_part(ar * br + ai * bi, den, sat);
          r.res_im = quot_part(ai * br - ar * bi, den, sat);
        end
      end
      FUNC_NEG: begin
        r.res_re = exact_part(-ar, 0, sat);
        r.res_im = exact_part(-ai, 0, sat);
      end
      FUNC_CONJ: begin
        r.res_re = exact_part(ar, 0, sat);
        r.res_im = exact_part(-ai, 0, sat);
      end
      FUNC_MAG: begin
        r.res_re = exact_part(ar * ar + ai * ai, FB, sat);
      end
      default: ;
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) expected_results.push_back(predict_result(item));
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: re %h im %h status %0d",
                 result.res_re, result.res_im, result.status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.res_re !== result.res_re)
            $error("res_re: expected %h, actual %h", want.res_re, result.res_re);
          if (want.res_im !== result.res_im)
            $error("res_im: expected %h, actual %h", want.res_im, result.res_im);
          if (want.status !== result.status)
            $error("status: expected %0d, actual %0d", want.status, result.status);
          if (want !== result) fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

[verif/complex_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the complex arithmetic unit: clock, reset, operand stimulus and verdict.
// Depends on cau_pkg, complex_arithmetic_unit and cau_checker.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int RAND_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  in_t   item;
  logic  done;
  out_t  result;
  int    fail_count;
  int    pending_count;
  int    cycle_count = 0;

  complex_arithmetic_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result)
  );

  cau_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    logic [31:0] specials[8] = '{32'h0, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h1, 32'hffff_ffff, 32'h0000_8000};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      2: return specials[$urandom_range(0, 7)];
      default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  // hold the beat until accepted; busy is sampled mid-cycle where it is settled
  task automatic send_beat(input in_t x, input int gap);
    logic b;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= x;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
  endtask

  function automatic in_t mk(input func_t f, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
    in_t x;
    x.func = f;
    x.a_re = ar;
    x.a_im = ai;
    x.b_re = br;
    x.b_im = bi;
    return x;
  endfunction

  initial begin
    in_t directed[$];
    in_t x;
    int  gap;
    int  burst;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff));
    directed.push_back(mk(FUNC_ADD, 32'h0001_0000, 32'hfffe_0000, 32'h0002_8000, 32'h3));
    directed.push_back(mk(FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff));
    directed.push_back(mk(FUNC_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
    directed.push_back(mk(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000));
    directed.push_back(mk(FUNC_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          32'h7fff_ffff));
    directed.push_back(mk(FUNC_MUL, 32'hffff_ffff, 32'h1, 32'h1, 32'h0000_8000));
    directed.push_back(mk(FUNC_MUL, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000,
                          32'h0000_8000));
    directed.push_back(mk(FUNC_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0));
    directed.push_back(mk(FUNC_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1));
    directed.push_back(mk(FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000));
    directed.push_back(mk(FUNC_DIV, 32'h0003_0000, 32'hffff_0000, 32'h0001_0000,
                          32'h0002_0000));
    directed.push_back(mk(FUNC_DIV, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h7fff_ffff));
    directed.push_back(mk(FUNC_NEG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    directed.push_back(mk(FUNC_NEG, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'hffff_ffff));
    directed.push_back(mk(FUNC_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    directed.push_back(mk(FUNC_CONJ, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0));
    directed.push_back(mk(FUNC_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    directed.push_back(mk(FUNC_MAG, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0));
    directed.push_back(mk(FUNC_MAG, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff));
    directed.push_back(mk(FUNC_NOP, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 32'h1));
    directed.push_back(mk(FUNC_NOP, 32'h0, 32'h0, 32'h0, 32'h0));
    foreach (directed[i]) send_beat(directed[i], (i % 3 == 0) ? 0 : i % 4);

    burst = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      x.func = ($urandom_range(0, 19) == 0) ? FUNC_NOP : func_t'($urandom_range(0, 6));
      x.a_re = pick_operand();
      x.a_im = pick_operand();
      x.b_re = pick_operand();
      x.b_im = pick_operand();
      if (x.func == FUNC_DIV && $urandom_range(0, 7) == 0) begin
        x.b_re = '0;
        x.b_im = '0;
      end
      // runs of back-to-back beats between stretches of random gaps
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        burst = $urandom_range(10, 60);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 9);
      end
      send_beat(x, gap);
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
